// ===== rtl/bpa_pkg.sv =====
// shared types, constants and codes for the buddy page allocator
`timescale 1ns / 1ps
package bpa_pkg;

    localparam int MAX_PAGES_DEF = 1024;
    localparam int TOP_ORDER_DEF = 10;
    localparam int PAGE_W        = 40;
    localparam int ORDER_W       = 4;
    localparam int COUNT_W       = 11;

    typedef enum logic [1:0] {
        CMD_INIT  = 2'd0,
        CMD_ALLOC = 2'd1,
        CMD_FREE  = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_NOMEM = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef enum logic {
        CFG_BASE  = 1'b0,
        CFG_COUNT = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        t_cmd               command;
        logic [ORDER_W-1:0] block_order;
        logic [PAGE_W-1:0]  page_number;
    } t_in_word;

    typedef struct packed {
        t_status           status;
        logic [PAGE_W-1:0] granted_page;
    } t_out_word;

    typedef struct packed {
        logic busy;
        logic res_valid;
    } t_ctrl_st;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_CARVE,
        S_ALLOC,
        S_A_LOOP,
        S_SPLIT_LO,
        S_SPLIT_HI,
        S_SPLIT_NEXT,
        S_GRANT,
        S_FREE,
        S_F_PUSH,
        S_M_TEST,
        S_M_RD,
        S_M_CHK,
        S_M_BUD,
        S_M_PUSH,
        S_U_RD,
        S_U_WR,
        S_P1,
        S_P2,
        S_DONE
    } t_state;

endpackage

// ===== rtl/bpa_ram.sv =====
// simple dual port memory, one write and one registered read per cycle
`timescale 1ns / 1ps
module bpa_ram import bpa_pkg::*; #(
    parameter int DEPTH = MAX_PAGES_DEF,
    parameter int WIDTH = 8,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== rtl/bpa_ctrl.sv =====
// allocator sequencer: list ends, page memories and the command state machine
`timescale 1ns / 1ps
module bpa_ctrl import bpa_pkg::*; #(
    parameter int MAX_PAGES = MAX_PAGES_DEF,
    parameter int TOP_ORDER = TOP_ORDER_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  t_in_word           i_in,
    input  logic [PAGE_W-1:0]  i_base,
    input  logic [COUNT_W-1:0] i_count,
    input  logic               i_res_free,
    output t_ctrl_st           o_st,
    output t_out_word          o_res
);

    localparam int IDX_W = $clog2(MAX_PAGES);
    localparam int LNK_W = $clog2(MAX_PAGES + 1);
    localparam int ORD_W = $clog2(TOP_ORDER + 2);
    localparam int LO_W  = $clog2(TOP_ORDER + 1);
    localparam logic [LNK_W-1:0] EMPTY = LNK_W'(MAX_PAGES);

    t_state             r_state, n_state;
    t_state             r_ret, n_ret;
    t_in_word           r_in, n_in;
    t_status            r_status, n_status;
    logic               r_gok, n_gok;
    logic               r_carve, n_carve;
    logic [ORD_W-1:0]   r_ord, n_ord;
    logic [ORD_W-1:0]   r_tgt, n_tgt;
    logic [ORD_W-1:0]   r_pord, n_pord;
    logic [IDX_W-1:0]   r_pg, n_pg;
    logic [IDX_W-1:0]   r_bud, n_bud;
    logic [IDX_W-1:0]   r_uaddr, n_uaddr;
    logic [IDX_W-1:0]   r_paddr, n_paddr;
    logic [IDX_W-1:0]   r_tail, n_tail;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic [LNK_W-1:0]   r_rem, n_rem;
    logic [LNK_W-1:0]   r_cbase, n_cbase;
    logic [LNK_W-1:0]   r_first [TOP_ORDER+1];
    logic [LNK_W-1:0]   n_first [TOP_ORDER+1];
    logic [LNK_W-1:0]   r_last  [TOP_ORDER+1];
    logic [LNK_W-1:0]   n_last  [TOP_ORDER+1];

    logic               fho_we, nxt_we, prv_we;
    logic [IDX_W-1:0]   fho_waddr, nxt_waddr, prv_waddr, raddr;
    logic [ORD_W-1:0]   fho_wdata, fho_rd;
    logic [LNK_W-1:0]   nxt_wdata, prv_wdata, nxt_rd, prv_rd;

    logic [LNK_W-1:0]   w_active;
    logic [PAGE_W-1:0]  w_off;
    logic               w_in_zone;
    logic               w_found;
    logic [ORD_W-1:0]   w_from;
    logic [ORD_W-1:0]   w_lo;
    logic [ORD_W-1:0]   w_uord;
    logic [31:0]        w_split_bud;
    logic [31:0]        w_merge_bud;
    logic [31:0]        w_size;
    logic [LNK_W-1:0]   w_tail;

    bpa_ram #(.DEPTH(MAX_PAGES), .WIDTH(ORD_W), .AW(IDX_W)) u_fho (
        .i_clk(i_clk), .i_we(fho_we), .i_waddr(fho_waddr), .i_wdata(fho_wdata),
        .i_raddr(raddr), .o_rdata(fho_rd)
    );
    bpa_ram #(.DEPTH(MAX_PAGES), .WIDTH(LNK_W), .AW(IDX_W)) u_nxt (
        .i_clk(i_clk), .i_we(nxt_we), .i_waddr(nxt_waddr), .i_wdata(nxt_wdata),
        .i_raddr(raddr), .o_rdata(nxt_rd)
    );
    bpa_ram #(.DEPTH(MAX_PAGES), .WIDTH(LNK_W), .AW(IDX_W)) u_prv (
        .i_clk(i_clk), .i_we(prv_we), .i_waddr(prv_waddr), .i_wdata(prv_wdata),
        .i_raddr(raddr), .o_rdata(prv_rd)
    );

    assign w_active = (32'(i_count) > MAX_PAGES) ? LNK_W'(MAX_PAGES) : LNK_W'(i_count);
    assign w_off = r_in.page_number - i_base;
    assign w_in_zone = (r_in.page_number >= i_base) && (w_off < PAGE_W'(w_active))
                       && (32'(r_in.block_order) <= TOP_ORDER);
    assign w_lo = r_ord - ORD_W'(1);
    assign w_uord = fho_rd - ORD_W'(1);
    assign w_split_bud = 32'(r_pg) ^ (32'd1 << w_lo);
    assign w_merge_bud = 32'(r_pg) ^ (32'd1 << r_ord);
    assign w_size = 32'd1 << r_ord;
    assign w_tail = r_last[r_pord[LO_W-1:0]];

    // lowest non-empty order at or above the request
    always_comb begin
        w_found = 1'b0;
        w_from  = '0;
        for (int k = TOP_ORDER; k >= 0; k--) begin
            if ((k >= 32'(r_in.block_order)) && (32'(r_first[k]) < MAX_PAGES)) begin
                w_found = 1'b1;
                w_from  = ORD_W'(k);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_idx   <= '0;
            r_carve <= 1'b0;
            for (int k = 0; k <= TOP_ORDER; k++) begin
                r_first[k] <= EMPTY;
                r_last[k]  <= EMPTY;
            end
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_carve <= n_carve;
            r_first <= n_first;
            r_last  <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ret    <= n_ret;
        r_in     <= n_in;
        r_status <= n_status;
        r_gok    <= n_gok;
        r_ord    <= n_ord;
        r_tgt    <= n_tgt;
        r_pord   <= n_pord;
        r_pg     <= n_pg;
        r_bud    <= n_bud;
        r_uaddr  <= n_uaddr;
        r_paddr  <= n_paddr;
        r_tail   <= n_tail;
        r_rem    <= n_rem;
        r_cbase  <= n_cbase;
    end

    always_comb begin
        n_state   = r_state;
        n_ret     = r_ret;
        n_in      = r_in;
        n_status  = r_status;
        n_gok     = r_gok;
        n_carve   = r_carve;
        n_ord     = r_ord;
        n_tgt     = r_tgt;
        n_pord    = r_pord;
        n_pg      = r_pg;
        n_bud     = r_bud;
        n_uaddr   = r_uaddr;
        n_paddr   = r_paddr;
        n_tail    = r_tail;
        n_idx     = r_idx;
        n_rem     = r_rem;
        n_cbase   = r_cbase;
        n_first   = r_first;
        n_last    = r_last;
        fho_we    = 1'b0;
        nxt_we    = 1'b0;
        prv_we    = 1'b0;
        fho_waddr = r_paddr;
        nxt_waddr = r_paddr;
        prv_waddr = r_paddr;
        fho_wdata = '0;
        nxt_wdata = EMPTY;
        prv_wdata = w_tail;
        raddr     = r_uaddr;
        o_st.busy      = (r_state != S_IDLE);
        o_st.res_valid = 1'b0;

        unique case (r_state)
            S_CLEAR: begin
                fho_we    = 1'b1;
                fho_waddr = r_idx;
                fho_wdata = '0;
                n_idx     = r_idx + IDX_W'(1);
                if (r_idx == IDX_W'(MAX_PAGES - 1)) begin
                    n_idx = '0;
                    for (int k = 0; k <= TOP_ORDER; k++) begin
                        n_first[k] = EMPTY;
                        n_last[k]  = EMPTY;
                    end
                    if (r_carve) begin
                        n_carve = 1'b0;
                        n_ord   = ORD_W'(TOP_ORDER);
                        n_rem   = w_active;
                        n_cbase = '0;
                        n_state = S_CARVE;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    n_in     = i_in;
                    n_status = ST_OK;
                    n_gok    = 1'b0;
                    unique case (i_in.command)
                        CMD_INIT: begin
                            n_carve = 1'b1;
                            n_idx   = '0;
                            n_state = S_CLEAR;
                        end
                        CMD_ALLOC: n_state = S_ALLOC;
                        CMD_FREE:  n_state = S_FREE;
                        default:   n_state = S_DONE;
                    endcase
                end
            end
            S_CARVE: begin
                if (32'(r_rem) >= w_size) begin
                    n_paddr = r_cbase[IDX_W-1:0];
                    n_pord  = r_ord;
                    n_cbase = r_cbase + LNK_W'(w_size);
                    n_rem   = r_rem - LNK_W'(w_size);
                    n_ret   = S_CARVE;
                    n_state = S_P1;
                end else if (r_ord == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_ord = r_ord - ORD_W'(1);
                end
            end
            S_ALLOC: begin
                if ((32'(r_in.block_order) > TOP_ORDER) || !w_found) begin
                    n_status = ST_NOMEM;
                    n_state  = S_DONE;
                end else begin
                    n_tgt   = ORD_W'(r_in.block_order);
                    n_ord   = w_from;
                    n_state = S_A_LOOP;
                end
            end
            S_A_LOOP: begin
                if (r_ord > r_tgt) begin
                    n_pg    = r_first[r_ord[LO_W-1:0]][IDX_W-1:0];
                    n_uaddr = r_first[r_ord[LO_W-1:0]][IDX_W-1:0];
                    n_ret   = S_SPLIT_LO;
                    n_state = S_U_RD;
                end else if (32'(r_first[r_tgt[LO_W-1:0]]) >= MAX_PAGES) begin
                    n_status = ST_NOMEM;
                    n_state  = S_DONE;
                end else begin
                    n_pg    = r_first[r_tgt[LO_W-1:0]][IDX_W-1:0];
                    n_uaddr = r_first[r_tgt[LO_W-1:0]][IDX_W-1:0];
                    n_ret   = S_GRANT;
                    n_state = S_U_RD;
                end
            end
            S_SPLIT_LO: begin
                n_paddr = r_pg;
                n_pord  = w_lo;
                n_ret   = S_SPLIT_HI;
                n_state = S_P1;
            end
            S_SPLIT_HI: begin
                if (w_split_bud < MAX_PAGES) begin
                    n_paddr = w_split_bud[IDX_W-1:0];
                    n_pord  = w_lo;
                    n_ret   = S_SPLIT_NEXT;
                    n_state = S_P1;
                end else begin
                    n_state = S_SPLIT_NEXT;
                end
            end
            S_SPLIT_NEXT: begin
                n_ord   = w_lo;
                n_state = S_A_LOOP;
            end
            S_GRANT: begin
                n_gok   = 1'b1;
                n_state = S_DONE;
            end
            S_FREE: begin
                if (!w_in_zone) begin
                    n_status = ST_RANGE;
                    n_state  = S_DONE;
                end else begin
                    n_pg    = w_off[IDX_W-1:0];
                    n_uaddr = w_off[IDX_W-1:0];
                    n_ord   = ORD_W'(r_in.block_order);
                    n_ret   = S_F_PUSH;
                    n_state = S_U_RD;
                end
            end
            S_F_PUSH: begin
                n_paddr = r_pg;
                n_pord  = r_ord;
                n_ret   = S_M_TEST;
                n_state = S_P1;
            end
            S_M_TEST: begin
                if ((32'(r_ord) >= TOP_ORDER) || (w_merge_bud >= 32'(w_active))
                    || (w_merge_bud >= MAX_PAGES)) begin
                    n_state = S_DONE;
                end else begin
                    n_bud   = w_merge_bud[IDX_W-1:0];
                    n_state = S_M_RD;
                end
            end
            S_M_RD: begin
                raddr   = r_bud;
                n_state = S_M_CHK;
            end
            S_M_CHK: begin
                if (fho_rd != (r_ord + ORD_W'(1))) begin
                    n_state = S_DONE;
                end else begin
                    n_uaddr = r_pg;
                    n_ret   = S_M_BUD;
                    n_state = S_U_RD;
                end
            end
            S_M_BUD: begin
                n_uaddr = r_bud;
                n_ret   = S_M_PUSH;
                n_state = S_U_RD;
            end
            S_M_PUSH: begin
                n_pg    = r_pg & r_bud;
                n_paddr = r_pg & r_bud;
                n_ord   = r_ord + ORD_W'(1);
                n_pord  = r_ord + ORD_W'(1);
                n_ret   = S_M_TEST;
                n_state = S_P1;
            end
            S_U_RD: begin
                raddr   = r_uaddr;
                n_state = S_U_WR;
            end
            S_U_WR: begin
                if ((fho_rd != '0) && (32'(fho_rd) <= TOP_ORDER + 1)) begin
                    if (32'(prv_rd) >= MAX_PAGES) begin
                        n_first[w_uord[LO_W-1:0]] = nxt_rd;
                    end else begin
                        nxt_we    = 1'b1;
                        nxt_waddr = prv_rd[IDX_W-1:0];
                        nxt_wdata = nxt_rd;
                    end
                    if (32'(nxt_rd) >= MAX_PAGES) begin
                        n_last[w_uord[LO_W-1:0]] = prv_rd;
                    end else begin
                        prv_we    = 1'b1;
                        prv_waddr = nxt_rd[IDX_W-1:0];
                        prv_wdata = prv_rd;
                    end
                    fho_we    = 1'b1;
                    fho_waddr = r_uaddr;
                    fho_wdata = '0;
                end
                n_state = r_ret;
            end
            S_P1: begin
                prv_we    = 1'b1;
                prv_waddr = r_paddr;
                prv_wdata = w_tail;
                nxt_we    = 1'b1;
                nxt_waddr = r_paddr;
                nxt_wdata = EMPTY;
                fho_we    = 1'b1;
                fho_waddr = r_paddr;
                fho_wdata = r_pord + ORD_W'(1);
                n_last[r_pord[LO_W-1:0]] = LNK_W'(r_paddr);
                if (32'(w_tail) >= MAX_PAGES) begin
                    n_first[r_pord[LO_W-1:0]] = LNK_W'(r_paddr);
                    n_state = r_ret;
                end else begin
                    n_tail  = w_tail[IDX_W-1:0];
                    n_state = S_P2;
                end
            end
            S_P2: begin
                nxt_we    = 1'b1;
                nxt_waddr = r_tail;
                nxt_wdata = LNK_W'(r_paddr);
                n_state   = r_ret;
            end
            S_DONE: begin
                if (i_res_free) begin
                    o_st.res_valid = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_res.status = r_status;
    assign o_res.granted_page = r_gok ? (i_base + PAGE_W'(r_pg)) : '0;

endmodule

// ===== rtl/buddy_page_allocator.sv =====
// buddy page allocator top level: handshake, configuration registers, result register
//
// input channel: i_in_valid / o_in_stall carry one command word (init, alloc, free);
// a word is taken when valid is high and stall is low. stall stays high while a
// command is worked on, so one command is in flight at a time.
// output channel: o_out_valid / i_out_stall carry one result word per command;
// the result register holds a word while the receiver stalls, and the next
// command is still taken meanwhile, its result waiting in the sequencer.
// config channel: i_cfg_valid / o_cfg_ready, index 0 zone base page, index 1
// zone page count; ready is always high and writes take effect at once.
// an alloc takes longer for each split level and a free for each merge level; init
// clears the page order memory and then carves the zone into blocks. the next
// command is taken the cycle after its result is registered. the timing is set by
// the one read port of the page memories and the two writes of a push.
// reset: a clearing pass over all MAX_PAGES entries wipes the page order memory; the
// input stays stalled until it ends, then all free lists are empty.
`timescale 1ns / 1ps
module buddy_page_allocator import bpa_pkg::*; #(
    parameter int MAX_PAGES = MAX_PAGES_DEF,
    parameter int TOP_ORDER = TOP_ORDER_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_word          i_in_word,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_word         o_out_word,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  t_cfg_reg          i_cfg_index,
    input  logic [PAGE_W-1:0] i_cfg_data
);

    logic [PAGE_W-1:0]  r_base;
    logic [COUNT_W-1:0] r_count;
    t_out_word          r_out;
    logic               r_out_valid;
    logic               w_res_free;
    t_ctrl_st           w_st;
    t_out_word          w_res;

    assign o_cfg_ready = 1'b1;
    assign w_res_free  = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= '0;
            r_count <= COUNT_W'(1024);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_BASE:  r_base  <= i_cfg_data;
                CFG_COUNT: r_count <= i_cfg_data[COUNT_W-1:0];
                default:   r_base  <= r_base;
            endcase
        end
    end

    bpa_ctrl #(.MAX_PAGES(MAX_PAGES), .TOP_ORDER(TOP_ORDER)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_in_valid && !w_st.busy),
        .i_in       (i_in_word),
        .i_base     (r_base),
        .i_count    (r_count),
        .i_res_free (w_res_free),
        .o_st       (w_st),
        .o_res      (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_st.res_valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_st.res_valid) begin
            r_out <= w_res;
        end
    end

    assign o_in_stall  = w_st.busy;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

`ifndef SYNTH
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("command accepted while another is in flight");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_st.res_valid |-> (!r_out_valid || !i_out_stall))
        else $error("result register overwritten while stalled");

    a_grant_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.status != ST_OK)) |-> (r_out.granted_page == '0))
        else $error("granted page set on failed command");
`endif

endmodule

// ===== dv/tb_top.sv =====
// self-checking testbench for the buddy page allocator with its own free-list predictor
`timescale 1ns / 1ps
module tb_top import bpa_pkg::*; ();

    localparam int NPAGES   = MAX_PAGES_DEF;
    localparam int TOPORD   = TOP_ORDER_DEF;
    localparam int NO_LINK  = NPAGES;
    localparam int WD_LIMIT = 6000;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_stall;
    t_in_word          i_in_word = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    t_out_word         o_out_word;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    t_cfg_reg          i_cfg_index = CFG_BASE;
    logic [PAGE_W-1:0] i_cfg_data = '0;

    buddy_page_allocator DUT (.*);

    always #6 i_clk = ~i_clk;

    // allocator state as predicted
    logic [PAGE_W-1:0]  zone_base = '0;
    logic [COUNT_W-1:0] zone_count = 11'd1024;
    int                 pg_head [NPAGES];
    int                 pg_next [NPAGES];
    int                 pg_prev [NPAGES];
    int                 ord_first [TOPORD+1];
    int                 ord_last [TOPORD+1];

    t_out_word         expected_words [$];
    logic [PAGE_W-1:0] held_page [$];
    int                held_order [$];

    int  mismatches = 0;
    int  n_alloc_ok = 0, n_free_ok = 0, n_nomem = 0, n_range = 0, n_words = 0;
    bit  quiet = 0;
    int  rx_wait = 0;
    int  rx_hold = 0;
    int  idle_cycles = 0;

    function automatic int active_pages();
        return (zone_count > NPAGES) ? NPAGES : int'(zone_count);
    endfunction

    function automatic void list_append(int o, int p);
        int t;
        if (o > TOPORD || p >= NPAGES) return;
        t = ord_last[o];
        pg_prev[p] = t;
        pg_next[p] = NO_LINK;
        if (t >= NPAGES) ord_first[o] = p;
        else pg_next[t] = p;
        ord_last[o] = p;
        pg_head[p] = o + 1;
    endfunction

    function automatic void list_unhook(int p);
        int o, pr, nx;
        if (p >= NPAGES || pg_head[p] == 0) return;
        o = pg_head[p] - 1;
        if (o > TOPORD) return;
        pr = pg_prev[p];
        nx = pg_next[p];
        if (pr >= NPAGES) ord_first[o] = nx;
        else pg_next[pr] = nx;
        if (nx >= NPAGES) ord_last[o] = pr;
        else pg_prev[nx] = pr;
        pg_head[p] = 0;
    endfunction

    function automatic void wipe_lists();
        for (int i = 0; i < NPAGES; i++) begin
            pg_head[i] = 0;
            pg_next[i] = 0;
            pg_prev[i] = 0;
        end
        for (int i = 0; i <= TOPORD; i++) begin
            ord_first[i] = NO_LINK;
            ord_last[i] = NO_LINK;
        end
    endfunction

    function automatic void carve_zone();
        int left, pos;
        left = active_pages();
        pos = 0;
        wipe_lists();
        for (int o = TOPORD; o >= 0; o--) begin
            while (left >= (1 << o)) begin
                list_append(o, pos);
                pos += 1 << o;
                left -= 1 << o;
            end
        end
    endfunction

    function automatic int grab_block(int o);
        int from, p, bud;
        if (o > TOPORD) return NO_LINK;
        from = o;
        while (from <= TOPORD && ord_first[from] >= NPAGES) from++;
        if (from > TOPORD) return NO_LINK;
        while (from > o) begin
            p = ord_first[from];
            list_unhook(p);
            bud = p ^ (1 << (from - 1));
            list_append(from - 1, p);
            if (bud < NPAGES) list_append(from - 1, bud);
            from--;
        end
        p = ord_first[o];
        if (p >= NPAGES) return NO_LINK;
        list_unhook(p);
        return p;
    endfunction

    function automatic void return_block(int p, int o);
        int lim, bud;
        lim = active_pages();
        list_unhook(p);
        list_append(o, p);
        while (o < TOPORD) begin
            bud = p ^ (1 << o);
            if (bud >= lim || bud >= NPAGES) break;
            if (pg_head[bud] != o + 1) break;
            list_unhook(p);
            list_unhook(bud);
            o++;
            p = p & bud;
            list_append(o, p);
        end
    endfunction

    function automatic t_out_word predict_word(t_in_word w);
        t_out_word         r;
        int                p, o;
        logic [PAGE_W-1:0] off;
        r = '{status: ST_OK, granted_page: '0};
        o = int'(w.block_order);
        case (w.command)
            CMD_INIT: begin
                carve_zone();
            end
            CMD_ALLOC: begin
                p = grab_block(o);
                if (p >= NPAGES) r.status = ST_NOMEM;
                else r.granted_page = zone_base + PAGE_W'(p);
            end
            CMD_FREE: begin
                off = w.page_number - zone_base;
                if (w.page_number < zone_base || o > TOPORD || off >= active_pages())
                    r.status = ST_RANGE;
                else return_block(int'(off), o);
            end
            default: ;
        endcase
        return r;
    endfunction

    // result check and receiver stall
    always @(posedge i_clk) begin
        if (o_out_valid && !i_out_stall) begin
            t_out_word e;
            if (expected_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word status=%0d page=%h",
                             o_out_word.status, o_out_word.granted_page);
            end else begin
                e = expected_words.pop_front();
                if (o_out_word.status !== e.status ||
                    o_out_word.granted_page !== e.granted_page) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp status=%0d page=%h, got status=%0d page=%h",
                                 e.status, e.granted_page,
                                 o_out_word.status, o_out_word.granted_page);
                end
            end
            rx_wait = quiet ? 0 : $urandom_range(0, 13);
        end
    end

    always @(negedge i_clk) begin
        if (rx_hold > 0) begin
            i_out_stall <= 1'b1;
            rx_hold--;
        end else if (rx_wait > 0) begin
            i_out_stall <= 1'b1;
            rx_wait--;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready))
            idle_cycles = 0;
        else if (i_rst_n) begin
            idle_cycles++;
            if (idle_cycles >= WD_LIMIT) begin
                $display("watchdog expired, %0d words still expected", expected_words.size());
                $display("tb_top NOT OK");
                $finish;
            end
        end
    end

    task automatic send_word(t_cmd c, logic [ORDER_W-1:0] o, logic [PAGE_W-1:0] pg);
        int        gap;
        t_in_word  w;
        t_out_word r;
        gap = quiet ? 0 : $urandom_range(0, 13);
        w = '{command: c, block_order: o, page_number: pg};
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word <= w;
        do @(posedge i_clk); while (o_in_stall);
        r = predict_word(w);
        expected_words.push_back(r);
        n_words++;
        if (c == CMD_INIT) begin
            held_page.delete();
            held_order.delete();
        end
        if (c == CMD_ALLOC && r.status == ST_OK) begin
            n_alloc_ok++;
            held_page.push_back(r.granted_page);
            held_order.push_back(int'(o));
        end
        if (c == CMD_FREE && r.status == ST_OK) n_free_ok++;
        if (r.status == ST_NOMEM) n_nomem++;
        if (r.status == ST_RANGE) n_range++;
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_reg idx, logic [PAGE_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_BASE) zone_base = val;
        else zone_count = val[COUNT_W-1:0];
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_directed();
        send_word(CMD_ALLOC, 4'd0, '0);
        send_word(CMD_INIT, 4'd0, '0);
        send_word(CMD_ALLOC, 4'd0, '0);
        send_word(CMD_ALLOC, 4'd10, '0);
        send_word(CMD_ALLOC, 4'd15, '0);
        send_word(CMD_ALLOC, 4'd11, '0);
        send_word(CMD_FREE, 4'd11, 40'd4);
        send_word(CMD_FREE, 4'd0, 40'd1024);
        send_word(CMD_FREE, 4'd0, '1);
        send_word(CMD_FREE, 4'd0, 40'd0);
        send_word(CMD_FREE, 4'd0, 40'd0);
        send_word(CMD_FREE, 4'd3, 40'd5);
        send_word(t_cmd'(2'd3), 4'd15, '1);
        for (int o = 0; o <= TOPORD; o++) send_word(CMD_ALLOC, o[3:0], '0);
        send_word(CMD_FREE, 4'd10, 40'd0);
        send_word(CMD_INIT, 4'd0, '0);
        wait_drained();
    endtask

    task automatic run_random(int n);
        int k, sel;
        for (int i = 0; i < n; i++) begin
            if (i % 100 == 0) quiet = ($urandom_range(0, 3) == 0);
            sel = $urandom_range(0, 99);
            if (sel < 45) begin
                send_word(CMD_ALLOC, ($urandom_range(0, 3) == 0) ?
                          4'($urandom_range(0, TOPORD)) : 4'($urandom_range(0, 2)), '0);
            end else if (sel < 88 && held_page.size() > 0) begin
                k = $urandom_range(0, held_page.size() - 1);
                send_word(CMD_FREE, held_order[k][3:0], held_page[k]);
                held_page.delete(k);
                held_order.delete(k);
            end else if (sel < 94) begin
                send_word(CMD_FREE, 4'($urandom_range(0, 15)),
                          zone_base + PAGE_W'($urandom_range(0, 1100)));
            end else if (sel < 97) begin
                send_word(t_cmd'(2'($urandom_range(1, 3))), 4'($urandom),
                          PAGE_W'({$urandom, $urandom}));
            end else if (sel < 98) begin
                send_word(CMD_INIT, 4'($urandom), PAGE_W'({$urandom, $urandom}));
            end else begin
                send_word(CMD_ALLOC, 4'($urandom_range(0, 15)),
                          PAGE_W'({$urandom, $urandom}));
            end
        end
        quiet = 0;
        wait_drained();
    endtask

    task automatic test_zone_settings();
        write_reg(CFG_BASE, 40'hFF_FFFF_FE00);
        write_reg(CFG_COUNT, 40'd1024);
        send_word(CMD_INIT, 4'd0, '0);
        run_random(200);
        write_reg(CFG_COUNT, 40'd0);
        send_word(CMD_INIT, 4'd0, '0);
        send_word(CMD_ALLOC, 4'd0, '0);
        send_word(CMD_FREE, 4'd0, 40'hFF_FFFF_FE00);
        wait_drained();
        write_reg(CFG_BASE, PAGE_W'({$urandom, $urandom}));
        write_reg(CFG_COUNT, 40'd2047);
        send_word(CMD_INIT, 4'd0, '0);
        run_random(150);
        write_reg(CFG_COUNT, 40'd1);
        send_word(CMD_INIT, 4'd0, '0);
        run_random(50);
        write_reg(CFG_BASE, 40'd3);
        write_reg(CFG_COUNT, 40'd37);
        send_word(CMD_INIT, 4'd0, '0);
        run_random(150);
        write_reg(CFG_COUNT, 40'd600);
        run_random(60);
    endtask

    task automatic test_backpressure();
        rx_hold = 400;
        quiet = 1;
        for (int i = 0; i < 12; i++) send_word(CMD_ALLOC, 4'($urandom_range(0, 2)), '0);
        quiet = 0;
        wait_drained();
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        wipe_lists();
        test_directed();
        write_reg(CFG_BASE, '0);
        write_reg(CFG_COUNT, 40'd1024);
        send_word(CMD_INIT, 4'd0, '0);
        run_random(550);
        test_backpressure();
        test_zone_settings();
        $display("%0d words: %0d allocs granted, %0d frees taken, %0d out of memory, %0d range",
                 n_words, n_alloc_ok, n_free_ok, n_nomem, n_range);
        $display("zone settings covered: full, empty, clamped, single page, odd size, wrapped base");
        if (mismatches == 0 && expected_words.size() == 0) begin
            $display("tb_top OK");
        end else begin
            $display("%0d mismatches, %0d words missing", mismatches, expected_words.size());
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
